// File: src/lrupr_pkg.sv
package lrupr_pkg;

  typedef struct packed {
    logic fill;
    logic touch;
    logic replace;
  } cell_cmd_t;

  typedef struct packed {
    logic match;
    logic lru;
  } cell_stat_t;

  localparam int CFG_BITS = 4;
  localparam int IDX_OUT_BITS = 3;
  localparam int FAULT_BITS = 32;

endpackage

// File: src/lrupr_cell.sv
module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = 16,
  parameter int RANK_BITS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_cmd_t            cmd,
  input  logic                 sel,
  input  logic                 prev_valid,
  input  logic [PAGE_BITS-1:0] page_in,
  input  logic [RANK_BITS-1:0] lru_rank,
  input  logic [RANK_BITS-1:0] sel_rank,
  output cell_stat_t           stat,
  output logic                 valid,
  output logic [PAGE_BITS-1:0] page,
  output logic [RANK_BITS-1:0] rank
);

  logic                 valid_r, valid_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [RANK_BITS-1:0] rank_r, rank_nxt;
  logic                 fill_me;

  assign fill_me = cmd.fill && prev_valid && !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    rank_nxt  = rank_r;
    if (cmd.fill) begin
      if (fill_me) begin
        valid_nxt = 1'b1;
        page_nxt  = page_in;
        rank_nxt  = '0;
      end else if (valid_r) begin
        rank_nxt = rank_r + 1'b1;
      end
    end else if (cmd.touch) begin
      if (sel) begin
        rank_nxt = '0;
        if (cmd.replace) begin
          page_nxt = page_in;
        end
      end else if (valid_r && (rank_r < sel_rank)) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  assign stat.match = valid_r && (page_r == page_in);
  assign stat.lru   = valid_r && (rank_r == lru_rank);
  assign valid      = valid_r;
  assign page       = page_r;
  assign rank       = rank_r;

endmodule

// File: src/lru_page_replacement.sv
// LRU page replacement unit. Each item is a page request on in_page, taken when start is
// high and busy is low. The request is looked up and the frame row is updated in the
// cycle after acceptance, during which busy is high. The result is on the out_ports with
// out_valid for exactly one cycle, the cycle after the lookup cycle. No new item is taken
// while busy is high, during the search-and-update cycle across the row of frame cells.
// The receiver cannot stall: each result is presented once and is lost if not captured.
// cfg_data written with cfg_we sets how many frames may be filled; zero acts as one and
// values above MAX_FRAMES act as MAX_FRAMES.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [PAGE_BITS-1:0]    in_page,
  input  logic                    cfg_we,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [IDX_OUT_BITS-1:0] out_frame_index,
  output logic                    out_evicted_valid,
  output logic [PAGE_BITS-1:0]    out_evicted_page,
  output logic [FAULT_BITS-1:0]   out_fault_count
);

  localparam int RW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW = $clog2(MAX_FRAMES + 1);
  localparam int LW = (FW > CFG_BITS) ? FW : CFG_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [PAGE_BITS-1:0]  page_r;
  logic [CFG_BITS-1:0]   limit_cfg_r;
  logic [FW-1:0]         filled_r, filled_nxt;
  logic [FAULT_BITS-1:0] faults_r, faults_nxt;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [IDX_OUT_BITS-1:0] out_idx_r;
  logic                    out_ev_valid_r;
  logic [PAGE_BITS-1:0]    out_ev_page_r;

  cell_cmd_t             cmd;
  cell_stat_t            stat   [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  pages  [MAX_FRAMES];
  logic [RW-1:0]         ranks  [MAX_FRAMES];
  logic [MAX_FRAMES:0]   chain_valid;
  logic [MAX_FRAMES-1:0] match_vec, lru_vec, sel_vec;

  logic                  run, hit, fill;
  logic [LW-1:0]         limit;
  logic [RW-1:0]         lru_rank, sel_rank, hit_idx, lru_idx, idx;
  logic [PAGE_BITS-1:0]  lru_page;
  logic [FW-1:0]         filled_m1;
  logic [RW+IDX_OUT_BITS-1:0] idx_ext;

  assign run  = (state_r == ST_RUN);
  assign busy = run;

  always_comb begin
    if (limit_cfg_r == '0) begin
      limit = LW'(1);
    end else if (LW'(limit_cfg_r) > LW'(MAX_FRAMES)) begin
      limit = LW'(MAX_FRAMES);
    end else begin
      limit = LW'(limit_cfg_r);
    end
  end

  assign filled_m1 = filled_r - 1'b1;
  assign lru_rank  = filled_m1[RW-1:0];

  assign chain_valid[0] = 1'b1;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .PAGE_BITS(PAGE_BITS),
      .RANK_BITS(RW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (sel_vec[g]),
      .prev_valid(chain_valid[g]),
      .page_in   (page_r),
      .lru_rank  (lru_rank),
      .sel_rank  (sel_rank),
      .stat      (stat[g]),
      .valid     (chain_valid[g+1]),
      .page      (pages[g]),
      .rank      (ranks[g])
    );
    assign match_vec[g] = stat[g].match;
    assign lru_vec[g]   = stat[g].lru;
  end

  always_comb begin
    hit_idx  = '0;
    lru_idx  = '0;
    lru_page = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      hit_idx  = hit_idx | (match_vec[i] ? RW'(i) : '0);
      lru_idx  = lru_idx | (lru_vec[i] ? RW'(i) : '0);
      lru_page = lru_page | (lru_vec[i] ? pages[i] : '0);
    end
  end

  assign hit     = |match_vec;
  assign fill    = !hit && (LW'(filled_r) < limit);
  assign sel_vec = hit ? match_vec : (fill ? '0 : lru_vec);

  always_comb begin
    sel_rank = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      sel_rank = sel_rank | (sel_vec[i] ? ranks[i] : '0);
    end
  end

  always_comb begin
    if (hit) begin
      idx = hit_idx;
    end else if (fill) begin
      idx = filled_r[RW-1:0];
    end else begin
      idx = lru_idx;
    end
  end

  assign idx_ext = {{IDX_OUT_BITS{1'b0}}, idx};

  assign cmd.fill    = run && fill;
  assign cmd.touch   = run && !fill;
  assign cmd.replace = run && !hit && !fill;

  always_comb begin
    state_nxt  = state_r;
    filled_nxt = filled_r;
    faults_nxt = faults_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_IDLE;
        if (fill) begin
          filled_nxt = filled_r + 1'b1;
        end
        if (!hit && (faults_r != '1)) begin
          faults_nxt = faults_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filled_r    <= '0;
      faults_r    <= '0;
      limit_cfg_r <= CFG_BITS'(3);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      faults_r    <= faults_nxt;
      out_valid_r <= run;
      if (cfg_we) begin
        limit_cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      page_r <= in_page;
    end
    if (run) begin
      out_hit_r      <= hit;
      out_idx_r      <= idx_ext[IDX_OUT_BITS-1:0];
      out_ev_valid_r <= !hit && !fill;
      out_ev_page_r  <= (!hit && !fill) ? lru_page : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_idx_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = faults_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    run |=> out_valid_r)
    else $error("lookup cycle did not produce a result");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("page resident in more than one frame");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_valid[MAX_FRAMES:1]) == int'(filled_r))
    else $error("valid cells disagree with filled count");

  a_single_lru: assert property (@(posedge clk) disable iff (!rst_n)
    (run && (filled_r != '0)) |-> $onehot(lru_vec))
    else $error("no unique least recently used frame");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> !out_ev_valid_r)
    else $error("eviction reported on a hit");

endmodule

// File: tb/lru_page_replacement_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_tb;
  import lrupr_pkg::*;

  localparam int NUM_FRAMES = 8;
  localparam int PAGE_W = 16;
  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic {
    OP_PAGE,
    OP_LIMIT
  } op_kind_t;

  typedef struct {
    op_kind_t          kind;
    logic [PAGE_W-1:0] value;
    int                gap;
  } op_t;

  typedef struct packed {
    logic                    hit;
    logic [IDX_OUT_BITS-1:0] frame_index;
    logic                    evicted_valid;
    logic [PAGE_W-1:0]       evicted_page;
    logic [FAULT_BITS-1:0]   fault_count;
  } lookup_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [PAGE_W-1:0]       in_page = '0;
  logic                    cfg_we = 1'b0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    out_valid;
  logic                    out_hit;
  logic [IDX_OUT_BITS-1:0] out_frame_index;
  logic                    out_evicted_valid;
  logic [PAGE_W-1:0]       out_evicted_page;
  logic [FAULT_BITS-1:0]   out_fault_count;

  op_t     request_q[$];
  lookup_t lookup_q[$];

  logic [PAGE_W-1:0]     frame_page[NUM_FRAMES];
  int                    frame_age[NUM_FRAMES];
  int                    frames_filled = 0;
  logic [FAULT_BITS-1:0] fault_total = '0;
  logic [CFG_BITS-1:0]   frame_limit_reg = CFG_BITS'(3);

  int gap_left = 0;
  int stall_cycles = 0;
  int n_pages = 0;
  int n_hits = 0;
  int n_evictions = 0;
  int n_limit_writes = 0;
  int n_errors = 0;

  lru_page_replacement #(
    .MAX_FRAMES(NUM_FRAMES),
    .PAGE_BITS (PAGE_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page          (in_page),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_frame_index  (out_frame_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_count  (out_fault_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int effective_limit();
    int lim;
    lim = frame_limit_reg;
    if (lim == 0) lim = 1;
    if (lim > NUM_FRAMES) lim = NUM_FRAMES;
    return lim;
  endfunction

  function automatic void make_recent(int sel, int n);
    int age;
    age = frame_age[sel];
    for (int i = 0; i < n; i++) begin
      if (frame_age[i] < age) frame_age[i]++;
    end
    frame_age[sel] = 0;
  endfunction

  function automatic lookup_t lookup_page(logic [PAGE_W-1:0] page);
    lookup_t r;
    int      n;
    int      sel;
    int      oldest;
    bit      found;
    r = '0;
    n = frames_filled;
    sel = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_page[i] == page) begin
        found = 1'b1;
        sel = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      make_recent(sel, n);
    end else begin
      if (fault_total != '1) fault_total++;
      if (n < effective_limit()) begin
        sel = n;
        for (int i = 0; i < n; i++) frame_age[i]++;
        frame_age[sel] = 0;
        frame_page[sel] = page;
        frames_filled = n + 1;
      end else begin
        oldest = 0;
        sel = 0;
        for (int i = 0; i < n; i++) begin
          if (i == 0 || frame_age[i] > oldest) begin
            oldest = frame_age[i];
            sel = i;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_page[sel];
        make_recent(sel, n);
        frame_page[sel] = page;
      end
    end
    r.frame_index = IDX_OUT_BITS'(sel);
    r.fault_count = fault_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  function automatic int pick_gap(bit idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_page(logic [PAGE_W-1:0] page, bit idle_on);
    op_t op;
    op.kind = OP_PAGE;
    op.value = page;
    op.gap = pick_gap(idle_on);
    request_q.push_back(op);
  endtask

  task automatic add_limit(int lim);
    op_t op;
    op.kind = OP_LIMIT;
    op.value = PAGE_W'(lim);
    op.gap = pick_gap(1'b1);
    request_q.push_back(op);
  endtask

  // An item is accepted at an edge where start is high and busy is low. A limit write
  // waits until no item is in flight and no result is being delivered at this edge.
  always @(posedge clk) begin : drive
    op_t  op;
    logic nxt_start;
    logic nxt_we;
    if (rst_n) begin
      nxt_start = start;
      nxt_we = 1'b0;
      if (start && !busy) begin
        lookup_q.push_back(lookup_page(in_page));
        n_pages++;
        nxt_start = 1'b0;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          op = request_q[0];
          if (op.kind == OP_PAGE) begin
            void'(request_q.pop_front());
            nxt_start = 1'b1;
            in_page <= op.value;
            gap_left = op.gap;
          end else if (lookup_q.size() == 0 && !out_valid && !start && !cfg_we) begin
            void'(request_q.pop_front());
            nxt_we = 1'b1;
            cfg_data <= op.value[CFG_BITS-1:0];
            frame_limit_reg = op.value[CFG_BITS-1:0];
            gap_left = op.gap;
            n_limit_writes++;
          end
        end
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  always @(posedge clk) begin : monitor
    lookup_t exp_r;
    if (rst_n && out_valid) begin
      if (lookup_q.size() == 0) begin
        $display("%0t: result with no item pending: hit %0d frame %0d fault_count %0d",
                 $time, out_hit, out_frame_index, out_fault_count);
        n_errors++;
      end else begin
        exp_r = lookup_q.pop_front();
        check_field("hit", exp_r.hit, out_hit);
        check_field("frame_index", exp_r.frame_index, out_frame_index);
        check_field("evicted_valid", exp_r.evicted_valid, out_evicted_valid);
        check_field("evicted_page", exp_r.evicted_page, out_evicted_page);
        check_field("fault_count", exp_r.fault_count, out_fault_count);
        if (exp_r.hit) n_hits++;
        if (exp_r.evicted_valid) n_evictions++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [PAGE_W-1:0] pool[16];
    int                pool_size;
    int                run_len;
    int                total;
    bit                idle_on;

    // Fill with the reset limit of three, then evict the least recently used page.
    add_page(16'h0000, 1'b1);
    add_page(16'hFFFF, 1'b1);
    add_page(16'h0000, 1'b1);
    add_page(16'h5555, 1'b1);
    add_page(16'hAAAA, 1'b1);
    add_page(16'hAAAA, 1'b1);
    add_page(16'h0001, 1'b1);
    // Open all eight frames and fill them.
    add_limit(NUM_FRAMES);
    for (int i = 2; i < 8; i++) add_page(PAGE_W'(i), 1'b1);
    add_page(16'h8000, 1'b1);
    add_page(16'h0003, 1'b1);
    // A limit below the filled count still searches and evicts across all filled frames.
    add_limit(2);
    add_page(16'h1234, 1'b1);
    add_page(16'h0005, 1'b1);
    // A limit of zero acts as one, and one above the frame count acts as the frame count.
    add_limit(0);
    add_page(16'h4321, 1'b1);
    add_limit(15);
    add_page(16'h7FFF, 1'b1);
    add_page(16'h1234, 1'b1);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: add_limit(0);
        1: add_limit(1);
        2: add_limit(NUM_FRAMES);
        3: add_limit(15);
        default: add_limit($urandom_range(0, 15));
      endcase
      pool_size = $urandom_range(2, 12);
      for (int i = 0; i < pool_size; i++) pool[i] = PAGE_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) begin
        pool[0] = '0;
        pool[1] = '1;
      end
      idle_on = ($urandom_range(0, 3) != 0);
      run_len = $urandom_range(40, 120);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          add_page(pool[$urandom_range(0, pool_size - 1)], idle_on);
        end else begin
          add_page(PAGE_W'($urandom_range(0, 65535)), idle_on);
        end
      end
      total += run_len;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || start || cfg_we || lookup_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    if (lookup_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, lookup_q.size());
      n_errors++;
    end
    $display("Ran %0d page requests across %0d frame limit writes.", n_pages, n_limit_writes);
    $display("Saw %0d hits, %0d evictions and %0d mismatches.", n_hits, n_evictions, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
